@@ sv/vgm_pkg.sv @@
// Shared constants, types and helpers for the volume gradient magnitude block.
package vgm_pkg;

    localparam int MAX_DIM_X  = 64;
    localparam int MAX_DIM_Y  = 64;
    localparam int MAX_DIM_Z  = 1024;
    localparam int NUM_FIELDS = 4;

    localparam int PLANE_MAX = MAX_DIM_X * MAX_DIM_Y;
    localparam int FWIN      = 2 * PLANE_MAX + 1;
    localparam int MWIN      = PLANE_MAX + 1;
    localparam int FW_AW     = $clog2(FWIN);
    localparam int MW_AW     = $clog2(MWIN);

    localparam int POS_W   = 22;
    localparam int DX_W    = $clog2(MAX_DIM_X + 1);
    localparam int DY_W    = $clog2(MAX_DIM_Y + 1);
    localparam int DZ_W    = $clog2(MAX_DIM_Z + 1);
    localparam int PLANE_W = $clog2(PLANE_MAX + 1);
    localparam int TOT_W   = $clog2(PLANE_MAX * MAX_DIM_Z + 1);
    localparam int REM_W   = (DX_W > DY_W) ? DX_W : DY_W;
    localparam int FC_W    = 3;
    localparam int WORD_W  = 16 * NUM_FIELDS;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_DIM_X  = 3'd0;
    localparam logic [2:0] CFG_DIM_Y  = 3'd1;
    localparam logic [2:0] CFG_DIM_Z  = 3'd2;
    localparam logic [2:0] CFG_INV_X  = 3'd3;
    localparam logic [2:0] CFG_INV_Y  = 3'd4;
    localparam logic [2:0] CFG_INV_Z  = 3'd5;
    localparam logic [2:0] CFG_FIELDS = 3'd6;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // arithmetic widths
    localparam int D_W    = 17;
    localparam int PROD_W = 42;
    localparam int DF_W   = 26;
    localparam int PP_W   = 52;
    localparam int GS_W   = 54;
    localparam int NPAIR  = 6;

    // pipeline: stage 1 is the window read, stages 10..25 the square root
    localparam int NST      = 25;
    localparam int SQ_FIRST = 10;

    // upper-triangle entries of the 3x3 structure matrix: diagonal first
    localparam int PAIR_L [NPAIR] = '{0, 1, 2, 0, 0, 1};
    localparam int PAIR_M [NPAIR] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic             res;
        logic             clr;
        logic             zero;
        logic             sat;
        logic             vend;
        logic [POS_W-1:0] idx;
    } ctl_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    // one digit of a restoring square root
    function automatic sqrt_t sqrt_step(sqrt_t s);
        logic [33:0] t;
        logic [33:0] trial;
        sqrt_t       o;
        t     = {s.rem[31:0], s.rad[63:62]};
        trial = {s.root, 2'b01};
        if (t >= trial)
        begin
            o.rem  = t - trial;
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = t;
            o.root = {s.root[30:0], 1'b0};
        end
        o.rad = {s.rad[61:0], 2'b00};
        return o;
    endfunction

    function automatic logic [FW_AW-1:0] fslot_fwd(logic [FW_AW-1:0] s,
                                                   logic [FW_AW-1:0] off);
        logic [FW_AW:0] t;
        t = {1'b0, s} + {1'b0, off};
        if (t >= (FW_AW+1)'(FWIN))
            t = t - (FW_AW+1)'(FWIN);
        return t[FW_AW-1:0];
    endfunction

    function automatic logic [FW_AW-1:0] fslot_back(logic [FW_AW-1:0] s,
                                                    logic [FW_AW-1:0] off);
        logic [FW_AW:0] t;
        t = {1'b0, s} + (FW_AW+1)'(FWIN) - {1'b0, off};
        if (t >= (FW_AW+1)'(FWIN))
            t = t - (FW_AW+1)'(FWIN);
        return t[FW_AW-1:0];
    endfunction

endpackage

@@ sv/vgm_ram.sv @@
// Generic single-write, single-read RAM with registered, write-first read.
module vgm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
        begin
            if (we && (waddr == raddr))
                rdata_reg <= wdata;
            else
                rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/volume_gradient_magnitude.sv @@
// Streaming 3D central-difference gradient norm with plane window buffers.
// Throughput: one item per cycle while in_stall is low; results trail the voxels by one plane
// of voxels. Each configuration write stalls input while voxel coordinates are rebuilt
// by a shared serial divider. Reset clears positions, counts and the running maximum;
// window memories hold no reset value and are valid only once written.
module volume_gradient_magnitude
    import vgm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [23:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             op,
    input  logic             voxel_valid,
    input  logic [15:0]      field_0,
    input  logic [15:0]      field_1,
    input  logic [15:0]      field_2,
    input  logic [15:0]      field_3,
    input  logic             clear_max,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [POS_W-1:0] voxel_index,
    output logic [31:0]      grad_magnitude,
    output logic [31:0]      running_max,
    output logic             volume_end
);

    localparam logic [1:0] RS_IDLE = 2'd0;
    localparam logic [1:0] RS_DIVX = 2'd1;
    localparam logic [1:0] RS_DIVY = 2'd2;

    // configuration
    logic [6:0]  cfg_dim_x_reg, cfg_dim_y_reg;
    logic [10:0] cfg_dim_z_reg;
    logic [23:0] cfg_inv_reg [3];
    logic [2:0]  cfg_fc_reg;

    logic [DX_W-1:0]    dx;
    logic [DY_W-1:0]    dy;
    logic [DZ_W-1:0]    dz;
    logic [FC_W-1:0]    fc;
    logic [PLANE_W-1:0] plane_reg;
    logic [TOT_W-1:0]   total_reg;

    // stream position state
    logic [POS_W-1:0]   in_pos_reg, out_pos_reg;
    logic [FW_AW-1:0]   in_fslot_reg, out_fslot_reg;
    logic [MW_AW-1:0]   in_mslot_reg, out_mslot_reg;
    logic [PLANE_W-1:0] pend_reg;
    logic [DX_W-1:0]    ox_reg;
    logic [DY_W-1:0]    oy_reg;
    logic [POS_W-1:0]   oz_reg;
    logic [31:0]        max_reg;

    // coordinate rebuild after a configuration write
    logic [1:0]         rs_state_reg;
    logic [4:0]         rs_cnt_reg;
    logic [REM_W-1:0]   rs_rem_reg;
    logic [POS_W-1:0]   rs_q_reg;
    logic [REM_W:0]     rs_t;
    logic [REM_W-1:0]   rs_rem_next;
    logic [POS_W-1:0]   rs_q_next;
    logic [REM_W:0]     rs_div;

    // pipeline control
    logic               v_reg   [1:NST];
    ctl_t               ctl_reg [1:NST];
    ctl_t               ctl_in  [2:NST];
    logic [NST+1:1]     en;
    logic               accept;

    // stage 0 decode
    logic               is_data, res, edge_hit, out_wrap, in_wrap, vend;
    logic [PLANE_W:0]   pend_inc;
    logic [PLANE_W-1:0] pend_next;
    logic [FW_AW-1:0]   raddr [6];
    logic [FW_AW-1:0]   off_dx, off_pl;
    logic [WORD_W-1:0]  word;
    logic [15:0]        fin [4];
    logic [FW_AW-1:0]   in_fslot_inc, out_fslot_inc;
    logic [MW_AW-1:0]   in_mslot_inc, out_mslot_inc;

    // datapath stages
    logic [WORD_W-1:0]        fr_rd [6];
    logic                     mask_rd;
    logic signed [PROD_W-1:0] prod_reg [NUM_FIELDS][3];
    logic signed [DF_W-1:0]   df_reg   [NUM_FIELDS][3];
    logic signed [PP_W-1:0]   pp_reg   [NUM_FIELDS][NPAIR];
    logic signed [GS_W-1:0]   gs_reg   [NPAIR];
    logic [31:0]              mag_reg  [NPAIR];
    logic [63:0]              sq_reg   [NPAIR];
    logic [PP_W-1:0]          ss5_reg, ss6_reg, ss7_reg, ss8_reg;
    logic [65:0]              pa_reg, pb_reg;
    sqrt_t                    sqst_reg [SQ_FIRST-1:NST];
    logic                     sat6;
    logic [31:0]              g_now, max_base, max_new;

    logic                     out_valid_reg, vend_reg;
    logic [POS_W-1:0]         idx_reg;
    logic [31:0]              grad_reg, rmax_reg;

    always_comb
    begin
        dx = (cfg_dim_x_reg == '0) ? DX_W'(1) :
             (cfg_dim_x_reg > MAX_DIM_X) ? DX_W'(MAX_DIM_X) : DX_W'(cfg_dim_x_reg);
        dy = (cfg_dim_y_reg == '0) ? DY_W'(1) :
             (cfg_dim_y_reg > MAX_DIM_Y) ? DY_W'(MAX_DIM_Y) : DY_W'(cfg_dim_y_reg);
        dz = (cfg_dim_z_reg == '0) ? DZ_W'(1) :
             (cfg_dim_z_reg > MAX_DIM_Z) ? DZ_W'(MAX_DIM_Z) : DZ_W'(cfg_dim_z_reg);
        fc = (cfg_fc_reg == '0) ? FC_W'(1) :
             (cfg_fc_reg > NUM_FIELDS) ? FC_W'(NUM_FIELDS) : cfg_fc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_dim_x_reg  <= 7'd64;
            cfg_dim_y_reg  <= 7'd64;
            cfg_dim_z_reg  <= 11'd64;
            cfg_inv_reg[0] <= 24'd32768;
            cfg_inv_reg[1] <= 24'd32768;
            cfg_inv_reg[2] <= 24'd32768;
            cfg_fc_reg     <= 3'd1;
            plane_reg      <= PLANE_W'(64 * 64);
            total_reg      <= TOT_W'(64 * 64 * 64);
        end
        else
        begin
            plane_reg <= PLANE_W'(dx * dy);
            total_reg <= TOT_W'(plane_reg * dz);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIM_X:  cfg_dim_x_reg  <= cfg_data[6:0];
                    CFG_DIM_Y:  cfg_dim_y_reg  <= cfg_data[6:0];
                    CFG_DIM_Z:  cfg_dim_z_reg  <= cfg_data[10:0];
                    CFG_INV_X:  cfg_inv_reg[0] <= cfg_data;
                    CFG_INV_Y:  cfg_inv_reg[1] <= cfg_data;
                    CFG_INV_Z:  cfg_inv_reg[2] <= cfg_data;
                    CFG_FIELDS: cfg_fc_reg     <= cfg_data[2:0];
                    default:    ;
                endcase
            end
        end
    end

    // handshake: a stage loads when it is empty or its successor loads
    always_comb
    begin
        en[NST+1] = !out_valid_reg || !out_stall;
        for (int k = NST; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_stall = !en[1] || (rs_state_reg != RS_IDLE);
    assign accept   = in_valid && !in_stall;

    // stage 0: window bookkeeping and read issue
    always_comb
    begin
        is_data  = (op == OP_DATA);
        pend_inc = {1'b0, pend_reg} + 1'b1;
        res      = is_data ? (pend_inc > {1'b0, plane_reg}) : (pend_reg != '0);
        if (is_data && !res)
            pend_next = pend_inc[PLANE_W-1:0];
        else if (!is_data && res)
            pend_next = pend_reg - 1'b1;
        else
            pend_next = pend_reg;

        edge_hit = (ox_reg == '0) || (({1'b0, ox_reg} + 2'd2) > {1'b0, dx}) ||
                   (oy_reg == '0) || (({1'b0, oy_reg} + 2'd2) > {1'b0, dy}) ||
                   (oz_reg == '0) || (({1'b0, oz_reg} + 2'd2) > (POS_W+1)'(dz));
        in_wrap  = (TOT_W'(in_pos_reg) + 1'b1) >= total_reg;
        out_wrap = (TOT_W'(out_pos_reg) + 1'b1) >= total_reg;
        vend     = (TOT_W'(out_pos_reg) + 1'b1) == total_reg;

        in_fslot_inc  = (in_fslot_reg == FW_AW'(FWIN - 1)) ? '0 : in_fslot_reg + 1'b1;
        out_fslot_inc = (out_fslot_reg == FW_AW'(FWIN - 1)) ? '0 : out_fslot_reg + 1'b1;
        in_mslot_inc  = (in_mslot_reg == MW_AW'(MWIN - 1)) ? '0 : in_mslot_reg + 1'b1;
        out_mslot_inc = (out_mslot_reg == MW_AW'(MWIN - 1)) ? '0 : out_mslot_reg + 1'b1;

        off_dx   = FW_AW'(dx);
        off_pl   = FW_AW'(plane_reg);
        raddr[0] = fslot_fwd(out_fslot_reg, FW_AW'(1));
        raddr[1] = fslot_back(out_fslot_reg, FW_AW'(1));
        raddr[2] = fslot_fwd(out_fslot_reg, off_dx);
        raddr[3] = fslot_back(out_fslot_reg, off_dx);
        raddr[4] = fslot_fwd(out_fslot_reg, off_pl);
        raddr[5] = fslot_back(out_fslot_reg, off_pl);

        fin[0] = field_0;
        fin[1] = field_1;
        fin[2] = field_2;
        fin[3] = field_3;
        for (int n = 0; n < NUM_FIELDS; n++)
            word[16*n +: 16] = fin[n];
    end

    // shared serial divider step
    always_comb
    begin
        rs_div      = (rs_state_reg == RS_DIVY) ? (REM_W+1)'(dy) : (REM_W+1)'(dx);
        rs_t        = {rs_rem_reg, rs_q_reg[POS_W-1]};
        rs_q_next   = {rs_q_reg[POS_W-2:0], 1'b0};
        rs_rem_next = rs_t[REM_W-1:0];
        if (rs_t >= rs_div)
        begin
            rs_rem_next  = REM_W'(rs_t - rs_div);
            rs_q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            in_fslot_reg  <= '0;
            out_fslot_reg <= '0;
            in_mslot_reg  <= '0;
            out_mslot_reg <= '0;
            pend_reg      <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            rs_state_reg  <= RS_IDLE;
            rs_cnt_reg    <= '0;
            rs_rem_reg    <= '0;
            rs_q_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                // rebuild x, y, z of the next voxel to report under the new grid
                rs_state_reg <= RS_DIVX;
                rs_cnt_reg   <= '0;
                rs_rem_reg   <= '0;
                rs_q_reg     <= out_pos_reg;
            end
            else if (rs_state_reg != RS_IDLE)
            begin
                rs_q_reg   <= rs_q_next;
                rs_rem_reg <= rs_rem_next;
                rs_cnt_reg <= rs_cnt_reg + 1'b1;
                if (rs_cnt_reg == 5'(POS_W - 1))
                begin
                    rs_cnt_reg <= '0;
                    rs_rem_reg <= '0;
                    if (rs_state_reg == RS_DIVX)
                    begin
                        ox_reg       <= DX_W'(rs_rem_next);
                        rs_state_reg <= RS_DIVY;
                    end
                    else
                    begin
                        oy_reg       <= DY_W'(rs_rem_next);
                        oz_reg       <= rs_q_next;
                        rs_state_reg <= RS_IDLE;
                    end
                end
            end

            if (accept)
            begin
                pend_reg <= pend_next;
                if (is_data)
                begin
                    in_pos_reg   <= in_wrap ? '0 : in_pos_reg + 1'b1;
                    in_fslot_reg <= in_wrap ? '0 : in_fslot_inc;
                    in_mslot_reg <= in_wrap ? '0 : in_mslot_inc;
                end
                if (res)
                begin
                    out_pos_reg   <= out_wrap ? '0 : out_pos_reg + 1'b1;
                    out_fslot_reg <= out_wrap ? '0 : out_fslot_inc;
                    out_mslot_reg <= out_wrap ? '0 : out_mslot_inc;
                    if (out_wrap)
                    begin
                        ox_reg <= '0;
                        oy_reg <= '0;
                        oz_reg <= '0;
                    end
                    else if (({1'b0, ox_reg} + 1'b1) == {1'b0, dx})
                    begin
                        ox_reg <= '0;
                        if (({1'b0, oy_reg} + 1'b1) == {1'b0, dy})
                        begin
                            oy_reg <= '0;
                            oz_reg <= oz_reg + 1'b1;
                        end
                        else
                            oy_reg <= oy_reg + 1'b1;
                    end
                    else
                        ox_reg <= ox_reg + 1'b1;
                end
            end
        end
    end

    // window memories: one copy of the field window per neighbor tap
    for (genvar j = 0; j < 6; j++)
    begin : g_fwin
        vgm_ram #(
            .WIDTH (WORD_W),
            .DEPTH (FWIN)
        ) u_fwin (
            .clk   (clk),
            .we    (accept && is_data),
            .waddr (in_fslot_reg),
            .wdata (word),
            .re    (en[1]),
            .raddr (raddr[j]),
            .rdata (fr_rd[j])
        );
    end

    vgm_ram #(
        .WIDTH (1),
        .DEPTH (MWIN)
    ) u_mwin (
        .clk   (clk),
        .we    (accept && is_data),
        .waddr (in_mslot_reg),
        .wdata (voxel_valid),
        .re    (en[1]),
        .raddr (out_mslot_reg),
        .rdata (mask_rd)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NST; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[1])
                v_reg[1] <= accept;
            for (int k = 2; k <= NST; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_comb
    begin
        for (int k = 2; k <= NST; k++)
            ctl_in[k] = ctl_reg[k-1];
        ctl_in[2].zero = ctl_reg[1].zero || !mask_rd;
        ctl_in[6].sat  = sat6;
        ctl_in[9].sat  = ctl_reg[8].sat && (fc != FC_W'(1));
    end

    // datapath: data registers need no reset
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ctl_reg[1].res  <= res;
            ctl_reg[1].clr  <= clear_max;
            ctl_reg[1].zero <= !is_data || edge_hit;
            ctl_reg[1].sat  <= 1'b0;
            ctl_reg[1].vend <= vend;
            ctl_reg[1].idx  <= out_pos_reg;
        end
        for (int k = 2; k <= NST; k++)
            if (en[k])
                ctl_reg[k] <= ctl_in[k];
    end

    // stage 2: central difference times axis scale
    always_ff @(posedge clk)
    begin
        logic signed [D_W-1:0]    d;
        logic signed [PROD_W-1:0] a_ext, b_ext;
        if (en[2])
        begin
            for (int n = 0; n < NUM_FIELDS; n++)
                for (int a = 0; a < 3; a++)
                begin
                    d = $signed({1'b0, fr_rd[2*a][16*n +: 16]}) -
                        $signed({1'b0, fr_rd[2*a+1][16*n +: 16]});
                    a_ext = PROD_W'(d);
                    b_ext = PROD_W'($signed({1'b0, cfg_inv_reg[a]}));
                    prod_reg[n][a] <= a_ext * b_ext;
                end
        end
    end

    // stage 3: round the Q.16 product to an integer, ties away from zero; drop unused fields
    always_ff @(posedge clk)
    begin
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        if (en[3])
        begin
            for (int n = 0; n < NUM_FIELDS; n++)
                for (int a = 0; a < 3; a++)
                begin
                    m = prod_reg[n][a][PROD_W-1] ? PROD_W'(-prod_reg[n][a])
                                                : PROD_W'(prod_reg[n][a]);
                    r = (m + PROD_W'(32'h8000)) >> 16;
                    if (n >= int'(fc))
                        df_reg[n][a] <= '0;
                    else if (prod_reg[n][a][PROD_W-1])
                        df_reg[n][a] <= -$signed(DF_W'(r));
                    else
                        df_reg[n][a] <= $signed(DF_W'(r));
                end
        end
    end

    // stage 4: per-field outer product entries
    always_ff @(posedge clk)
    begin
        logic signed [PP_W-1:0] a_ext, b_ext;
        if (en[4])
        begin
            for (int n = 0; n < NUM_FIELDS; n++)
                for (int e = 0; e < NPAIR; e++)
                begin
                    a_ext = PP_W'(df_reg[n][PAIR_L[e]]);
                    b_ext = PP_W'(df_reg[n][PAIR_M[e]]);
                    pp_reg[n][e] <= a_ext * b_ext;
                end
        end
    end

    // stage 5: sum over fields; single-field sum of squares
    always_ff @(posedge clk)
    begin
        logic signed [GS_W-1:0] acc;
        if (en[5])
        begin
            for (int e = 0; e < NPAIR; e++)
            begin
                acc = '0;
                for (int n = 0; n < NUM_FIELDS; n++)
                    acc = acc + GS_W'(pp_reg[n][e]);
                gs_reg[e] <= acc;
            end
            ss5_reg <= PP_W'(pp_reg[0][0]) + PP_W'(pp_reg[0][1]) + PP_W'(pp_reg[0][2]);
        end
    end

    // stage 6: round matrix entries, flag entries at or above 2^32
    always_comb
    begin
        logic [GS_W-1:0] m;
        logic [GS_W-1:0] r;
        sat6 = 1'b0;
        for (int e = 0; e < NPAIR; e++)
        begin
            m = gs_reg[e][GS_W-1] ? GS_W'(-gs_reg[e]) : GS_W'(gs_reg[e]);
            r = (m + GS_W'(32'h8000)) >> 16;
            if (r[GS_W-1:32] != '0)
                sat6 = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [GS_W-1:0] m;
        logic [GS_W-1:0] r;
        if (en[6])
        begin
            for (int e = 0; e < NPAIR; e++)
            begin
                m = gs_reg[e][GS_W-1] ? GS_W'(-gs_reg[e]) : GS_W'(gs_reg[e]);
                r = (m + GS_W'(32'h8000)) >> 16;
                mag_reg[e] <= r[31:0];
            end
            ss6_reg <= ss5_reg;
        end
    end

    // stage 7: squares of entries
    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            for (int e = 0; e < NPAIR; e++)
                sq_reg[e] <= 64'(mag_reg[e]) * 64'(mag_reg[e]);
            ss7_reg <= ss6_reg;
        end
    end

    // stage 8: diagonal and off-diagonal partial sums
    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            pa_reg  <= 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
            pb_reg  <= 66'(sq_reg[3]) + 66'(sq_reg[4]) + 66'(sq_reg[5]);
            ss8_reg <= ss7_reg;
        end
    end

    // stage 9: radicand, saturating at 2^64 - 1
    always_ff @(posedge clk)
    begin
        logic [67:0] sum;
        if (en[9])
        begin
            sum = {2'b00, pa_reg} + {1'b0, pb_reg, 1'b0};
            if (fc == FC_W'(1))
                sqst_reg[SQ_FIRST-1].rad <= 64'(ss8_reg);
            else if (sum[67:64] != '0)
                sqst_reg[SQ_FIRST-1].rad <= '1;
            else
                sqst_reg[SQ_FIRST-1].rad <= sum[63:0];
            sqst_reg[SQ_FIRST-1].rem  <= '0;
            sqst_reg[SQ_FIRST-1].root <= '0;
        end
    end

    // stages 10..25: two root bits per stage
    always_ff @(posedge clk)
    begin
        for (int k = SQ_FIRST; k <= NST; k++)
            if (en[k])
                sqst_reg[k] <= sqrt_step(sqrt_step(sqst_reg[k-1]));
    end

    // output stage: clear, then update the running maximum in item order
    always_comb
    begin
        if (ctl_reg[NST].zero)
            g_now = '0;
        else if (ctl_reg[NST].sat)
            g_now = '1;
        else
            g_now = sqst_reg[NST].root;
        max_base = ctl_reg[NST].clr ? '0 : max_reg;
        max_new  = (ctl_reg[NST].res && (g_now > max_base)) ? g_now : max_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
        end
        else if (en[NST+1])
        begin
            out_valid_reg <= v_reg[NST] && ctl_reg[NST].res;
            if (v_reg[NST])
                max_reg <= max_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST+1] && v_reg[NST] && ctl_reg[NST].res)
        begin
            idx_reg  <= ctl_reg[NST].idx;
            grad_reg <= g_now;
            rmax_reg <= max_new;
            vend_reg <= ctl_reg[NST].vend;
        end
    end

    assign out_valid      = out_valid_reg;
    assign voxel_index    = idx_reg;
    assign grad_magnitude = grad_reg;
    assign running_max    = rmax_reg;
    assign volume_end     = vend_reg;

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PLANE_W'(PLANE_MAX))
        else $error("pending voxel count beyond one plane");

    a_no_accept_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (rs_state_reg != RS_IDLE) |-> in_stall)
        else $error("input taken while coordinates are rebuilt");

    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rs_state_reg == RS_IDLE) |-> ((ox_reg < dx) && (oy_reg < dy)))
        else $error("output voxel coordinates outside the grid");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fslot_reg < FW_AW'(FWIN)) && (out_fslot_reg < FW_AW'(FWIN)) &&
        (in_mslot_reg < MW_AW'(MWIN)) && (out_mslot_reg < MW_AW'(MWIN)))
        else $error("window slot beyond memory depth");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the volume gradient magnitude block.
module tb;
    import vgm_pkg::*;

    typedef struct {
        logic        op;
        logic        vv;
        logic [15:0] f [4];
        logic        clr;
    } voxel_item_t;

    typedef struct {
        logic [21:0] idx;
        logic [31:0] grad;
        logic [31:0] peak;
        logic        vend;
    } grad_result_t;

    class grad_scoreboard;
        longint unsigned field_mem [FWIN];
        bit              mask_mem [MWIN];
        longint unsigned in_pos, out_pos, pending;
        bit [31:0]       peak;
        longint unsigned reg_val [7];
        grad_result_t    exp_q [$];
        int              errors;

        function void clear_state();
            foreach (field_mem[i]) field_mem[i] = 0;
            foreach (mask_mem[i]) mask_mem[i] = 0;
            in_pos = 0;
            out_pos = 0;
            pending = 0;
            peak = 0;
            errors = 0;
            reg_val = '{64, 64, 64, 32768, 32768, 32768, 1};
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                CFG_DIM_X, CFG_DIM_Y: reg_val[idx] = val[6:0];
                CFG_DIM_Z:            reg_val[idx] = val[10:0];
                CFG_FIELDS:           reg_val[idx] = val[2:0];
                default:              reg_val[idx] = val;
            endcase
        endfunction

        function longint unsigned clamp(longint unsigned v, longint unsigned hi);
            if (v < 1) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function longint round16(longint v);
            longint unsigned m;
            m = (v < 0) ? -v : v;
            m = (m + 64'h8000) >> 16;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint fval(longint unsigned slot, int k);
            return longint'((field_mem[slot % FWIN] >> (16 * k)) & 64'hFFFF);
        endfunction

        function bit [31:0] norm_at(longint unsigned p, longint unsigned dx,
                                    longint unsigned dy, longint unsigned dz);
            longint unsigned x, y, z, fc, s, mag, sq;
            longint unsigned off [3];
            longint          df [4][3];
            longint          d, g;
            x = p % dx;
            y = (p / dx) % dy;
            z = p / (dx * dy);
            if (x < 1 || x + 2 > dx || y < 1 || y + 2 > dy || z < 1 || z + 2 > dz)
                return 0;
            if (!mask_mem[p % MWIN])
                return 0;
            off = '{1, dx, dx * dy};
            fc = clamp(reg_val[CFG_FIELDS], NUM_FIELDS);
            for (int n = 0; n < fc; n++)
                for (int a = 0; a < 3; a++)
                begin
                    d = fval(p + off[a], n) - fval(p + FWIN - off[a], n);
                    df[n][a] = round16(d * longint'(reg_val[CFG_INV_X + a]));
                end
            s = 0;
            if (fc == 1)
            begin
                for (int a = 0; a < 3; a++)
                    s += longint'(df[0][a] * df[0][a]);
                return floor_sqrt(s);
            end
            for (int l = 0; l < 3; l++)
                for (int m = 0; m < 3; m++)
                begin
                    g = 0;
                    for (int n = 0; n < fc; n++)
                        g += df[n][l] * df[n][m];
                    g = round16(g);
                    mag = (g < 0) ? -g : g;
                    if (mag >= (64'd1 << 32))
                        return 32'hFFFF_FFFF;
                    sq = mag * mag;
                    s = (s > ~64'd0 - sq) ? ~64'd0 : s + sq;
                end
            return floor_sqrt(s);
        endfunction

        // note one accepted input transfer and queue the result it causes
        function void note(voxel_item_t it);
            longint unsigned dx, dy, dz, plane, total, p;
            bit [31:0]       g;
            grad_result_t    r;
            dx = clamp(reg_val[CFG_DIM_X], MAX_DIM_X);
            dy = clamp(reg_val[CFG_DIM_Y], MAX_DIM_Y);
            dz = clamp(reg_val[CFG_DIM_Z], MAX_DIM_Z);
            plane = dx * dy;
            total = plane * dz;
            g = 0;
            if (it.clr)
                peak = 0;
            if (it.op == OP_DATA)
            begin
                field_mem[in_pos % FWIN] = {it.f[3], it.f[2], it.f[1], it.f[0]};
                mask_mem[in_pos % MWIN] = it.vv;
                in_pos = (in_pos + 1 >= total) ? 0 : in_pos + 1;
                pending++;
                if (pending <= plane)
                    return;
                g = norm_at(out_pos, dx, dy, dz);
            end
            else if (pending == 0)
                return;
            p = out_pos;
            if (g > peak)
                peak = g;
            r.idx = p[21:0];
            r.grad = g;
            r.peak = peak;
            r.vend = (p + 1 == total);
            exp_q.push_back(r);
            out_pos = (p + 1 >= total) ? 0 : p + 1;
            pending--;
        endfunction

        function void check(grad_result_t got);
            grad_result_t e;
            if (exp_q.size() == 0)
            begin
                $display("%0t unexpected result at voxel %0d", $time, got.idx);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (got.idx !== e.idx)
            begin
                $display("%0t voxel_index exp %0d got %0d", $time, e.idx, got.idx);
                errors++;
            end
            if (got.grad !== e.grad)
            begin
                $display("%0t grad_magnitude exp %h got %h", $time, e.grad, got.grad);
                errors++;
            end
            if (got.peak !== e.peak)
            begin
                $display("%0t running_max exp %h got %h", $time, e.peak, got.peak);
                errors++;
            end
            if (got.vend !== e.vend)
            begin
                $display("%0t volume_end exp %b got %b", $time, e.vend, got.vend);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [23:0]      cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic             op;
    logic             voxel_valid;
    logic [15:0]      field_0, field_1, field_2, field_3;
    logic             clear_max;
    logic             out_valid;
    logic             out_stall;
    logic [POS_W-1:0] voxel_index;
    logic [31:0]      grad_magnitude;
    logic [31:0]      running_max;
    logic             volume_end;

    grad_scoreboard sb;
    bit             quiet;
    bit             hold_req;
    int             sent;

    volume_gradient_magnitude i_dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #2000000;
        $display("volume_gradient_magnitude: mismatch");
        $finish;
    end

    task automatic send(input voxel_item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= it.op;
        voxel_valid <= it.vv;
        field_0     <= it.f[0];
        field_1     <= it.f[1];
        field_2     <= it.f[2];
        field_3     <= it.f[3];
        clear_max   <= it.clr;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        sb.note(it);
        sent++;
    endtask

    task automatic send_flushes();
        voxel_item_t it;
        it.op = OP_FLUSH;
        it.vv = 1'b0;
        it.f = '{16'h0, 16'h0, 16'h0, 16'h0};
        while (sb.pending != 0)
        begin
            it.clr = ($urandom_range(0, 31) == 0);
            send(it);
        end
    endtask

    // drop valid and hold until every queued result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(input int dx, input int dy, input int dz, input int ix,
                              input int iy, input int iz, input int fc);
        int vals [7];
        vals = '{dx, dy, dz, ix, iy, iz, fc};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i][23:0];
            @(posedge clk);
            sb.set_reg(i[2:0], vals[i][23:0]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_inv();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 24'hFFFFFF;
            2: return 32768;
            default: return $urandom_range(0, 24'hFFFFFF);
        endcase
    endfunction

    function automatic logic [15:0] pick_field(int style, logic [15:0] base);
        case (style)
            0: return $urandom;
            1: return base + $urandom_range(0, 255);
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // feed n data voxels with occasional flush ticks mixed in
    task automatic feed(input int n, input int style, input bit pause_mid);
        voxel_item_t it;
        voxel_item_t fl;
        logic [15:0] base [4];
        fl.op = OP_FLUSH;
        fl.vv = 1'b0;
        fl.f = '{16'h0, 16'h0, 16'h0, 16'h0};
        fl.clr = 1'b0;
        for (int k = 0; k < 4; k++) base[k] = $urandom;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send(fl);
            if (pause_mid && i == n / 2)
            begin
                in_valid <= 1'b0;
                while (sb.exp_q.size() != 0) @(posedge clk);
            end
            it.op = OP_DATA;
            it.vv = ($urandom_range(0, 7) != 0);
            for (int k = 0; k < 4; k++)
            begin
                it.f[k] = pick_field(style, base[k]);
                base[k] = base[k] + $urandom_range(0, 511);
            end
            it.clr = ($urandom_range(0, 31) == 0);
            send(it);
        end
    endtask

    function automatic int clamp_dim(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    initial
    begin
        voxel_item_t it;
        int          dx, dy, dz, vols, ph;
        sb = new();
        sb.clear_state();
        quiet = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_DIM_X;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        op          <= OP_DATA;
        voxel_valid <= 1'b0;
        field_0     <= '0;
        field_1     <= '0;
        field_2     <= '0;
        field_3     <= '0;
        clear_max   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // checkerboard of extreme values: the central differences cancel, so the multi-field norm at the center is zero
        set_config(3, 3, 3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 7);
        it.op = OP_FLUSH;
        it.vv = 1'b1;
        it.f = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        it.clr = 1'b1;
        send(it);
        for (int i = 0; i < 27; i++)
        begin
            it.op = OP_DATA;
            it.vv = (i != 4);
            for (int k = 0; k < 4; k++)
                it.f[k] = ((i + k) % 2 != 0) ? 16'hFFFF : 16'h0000;
            it.clr = (i == 20);
            send(it);
        end
        send_flushes();
        drain();

        ph = 0;
        while (sent < 800)
        begin
            case (ph)
                0:
                begin
                    dx = 127; dy = 2; dz = 3;
                    set_config(dx, dy, dz, 32768, 32768, 32768, 1);
                    hold_req = 1'b1;
                end
                1:
                begin
                    dx = 2; dy = 127; dz = 3;
                    set_config(dx, dy, dz, pick_inv(), pick_inv(), pick_inv(), 0);
                end
                2:
                begin
                    dx = 0; dy = 0; dz = 0;
                    set_config(dx, dy, dz, pick_inv(), pick_inv(), pick_inv(), 4);
                end
                default:
                begin
                    dx = $urandom_range(0, 8);
                    dy = $urandom_range(0, 8);
                    dz = $urandom_range(0, 7);
                    set_config(dx, dy, dz, pick_inv(), pick_inv(), pick_inv(),
                               $urandom_range(0, 7));
                end
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            vols = (ph < 2) ? 1 : $urandom_range(1, 2);
            feed(vols * clamp_dim(dx, 64) * clamp_dim(dy, 64) * clamp_dim(dz, 1024),
                 $urandom_range(0, 2), ph == 3);
            send_flushes();
            drain();
            ph++;
        end

        // deepest z: feed part of the volume only
        quiet = 1'b0;
        set_config(3, 3, 2047, pick_inv(), pick_inv(), pick_inv(), 2);
        feed(150, 1, 1'b0);
        send_flushes();
        drain();

        if (sb.errors == 0)
            $display("volume_gradient_magnitude: match");
        else
            $display("volume_gradient_magnitude: mismatch");
        $finish;
    end

    // receiver: random hold-off per result, one long hold-off on request
    initial
    begin
        grad_result_t got;
        int           k;
        out_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            k = quiet ? 0 : $urandom_range(0, 6);
            if (k != 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(negedge clk); while (!out_valid);
            got.idx = voxel_index;
            got.grad = grad_magnitude;
            got.peak = running_max;
            got.vend = volume_end;
            sb.check(got);
            @(posedge clk);
        end
    end

endmodule
